>>> src/scua_pkg.sv
// Shared types, codes and reset constants for the size class unit allocator.
`timescale 1ns / 1ps

package scua_pkg;

  localparam int NUM_POOLS_DEF  = 4;
  localparam int MAX_UNITS_DEF  = 64;
  localparam int POOL_SLOTS     = 4;
  localparam int UNIT_REACH     = 64;
  localparam int SIZE_W         = 16;
  localparam int COUNT_W        = 7;
  localparam int UNIT_W         = 6;
  localparam int POOL_W         = 2;
  localparam int FUNC_W         = 2;
  localparam int STATUS_W       = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_SIZE_BASE  = 0;
  localparam int CFG_COUNT_BASE = 4;
  localparam int UNIT_COUNT_RST = 64;

  localparam logic [POOL_SLOTS-1:0][SIZE_W-1:0] UNIT_SIZE_RST = {
    16'd128, 16'd64, 16'd32, 16'd16
  };

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_REBUILD = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_FIT    = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_RANGE     = 3'd3,
    STAT_STACK_FUL = 3'd4
  } status_e;

  typedef struct packed {
    logic [POOL_SLOTS-1:0][SIZE_W-1:0]  unit_size;
    logic [POOL_SLOTS-1:0][COUNT_W-1:0] eff_count;
  } cfg_t;

endpackage

>>> src/scua_cfg_regs.sv
// Configuration registers: unit sizes and clamped unit counts per pool.
`timescale 1ns / 1ps

module scua_cfg_regs #(
  parameter int MAX_UNITS = scua_pkg::MAX_UNITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scua_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [scua_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output scua_pkg::cfg_t                       cfg_o
);
  import scua_pkg::*;

  localparam int UNIT_LIMIT = (MAX_UNITS < UNIT_REACH) ? MAX_UNITS : UNIT_REACH;

  logic [POOL_SLOTS-1:0][SIZE_W-1:0]  size_q;
  logic [POOL_SLOTS-1:0][COUNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= UNIT_SIZE_RST;
      for (int p = 0; p < POOL_SLOTS; p++) begin
        count_q[p] <= COUNT_W'(UNIT_COUNT_RST);
      end
    end else if (cfg_we_i) begin
      for (int p = 0; p < POOL_SLOTS; p++) begin
        if (cfg_idx_i == CFG_IDX_W'(CFG_SIZE_BASE + p)) begin
          size_q[p] <= cfg_wdata_i[SIZE_W-1:0];
        end
        if (cfg_idx_i == CFG_IDX_W'(CFG_COUNT_BASE + p)) begin
          count_q[p] <= cfg_wdata_i[COUNT_W-1:0];
        end
      end
    end
  end

  always_comb begin
    cfg_o.unit_size = size_q;
    for (int p = 0; p < POOL_SLOTS; p++) begin
      cfg_o.eff_count[p] = (count_q[p] > COUNT_W'(UNIT_LIMIT)) ? COUNT_W'(UNIT_LIMIT)
                                                              : count_q[p];
    end
  end

endmodule

>>> src/scua_stack_ram.sv
// Freed-unit stack storage: one write port, one registered read port.
`timescale 1ns / 1ps

module scua_stack_ram #(
  parameter int DEPTH  = scua_pkg::NUM_POOLS_DEF * scua_pkg::MAX_UNITS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [scua_pkg::UNIT_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [scua_pkg::UNIT_W-1:0] rdata_o
);
  import scua_pkg::*;

  logic [UNIT_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/size_class_unit_allocator.sv
// Top level of the size class unit allocator: request control and pool counters.
// Free, rebuild, failed allocate and fresh-unit allocate give their result in the
// cycle after acceptance; a popping allocate reads the stack memory into its
// registered read port and then loads the result register from it.
// Throughput: one transaction per cycle, held off by output stalls and stack pops.
// Reset: pools hold their clamped reset counts, all stacks empty; stack memory is
// not cleared since only pushed entries are ever read back.
`timescale 1ns / 1ps

module size_class_unit_allocator #(
  parameter int NUM_POOLS = scua_pkg::NUM_POOLS_DEF,
  parameter int MAX_UNITS = scua_pkg::MAX_UNITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scua_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scua_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [scua_pkg::FUNC_W-1:0]     func_i,
  input  logic [scua_pkg::SIZE_W-1:0]     req_size_i,
  input  logic [scua_pkg::POOL_W-1:0]     free_pool_i,
  input  logic [scua_pkg::UNIT_W-1:0]     free_unit_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [scua_pkg::STATUS_W-1:0]   status_o,
  output logic [scua_pkg::POOL_W-1:0]     pool_o,
  output logic [scua_pkg::UNIT_W-1:0]     unit_o,
  output logic [scua_pkg::POOL_SLOTS-1:0] full_mask_o
);
  import scua_pkg::*;

  localparam int DEPTH      = NUM_POOLS * MAX_UNITS;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DEPTH_W    = $clog2(MAX_UNITS + 1);
  localparam int IDX_W      = $clog2(MAX_UNITS);
  localparam int UNIT_LIMIT = (MAX_UNITS < UNIT_REACH) ? MAX_UNITS : UNIT_REACH;
  localparam int FRESH_RST  = (UNIT_COUNT_RST > UNIT_LIMIT) ? UNIT_LIMIT : UNIT_COUNT_RST;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_e;

  cfg_t cfg;

  state_e state_q, state_d;
  logic [COUNT_W-1:0] fresh_q [POOL_SLOTS];
  logic [COUNT_W-1:0] fresh_d [POOL_SLOTS];
  logic [DEPTH_W-1:0] depth_q [POOL_SLOTS];
  logic [DEPTH_W-1:0] depth_d [POOL_SLOTS];

  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   status_q;
  logic [POOL_W-1:0]     pool_q;
  logic [UNIT_W-1:0]     unit_q;
  logic [POOL_SLOTS-1:0] mask_q;

  logic                  in_acc;
  logic                  sel_found;
  logic [POOL_W-1:0]     sel_pool;
  status_e               res_status;
  logic [POOL_W-1:0]     res_pool;
  logic [UNIT_W-1:0]     res_unit;
  logic [POOL_SLOTS-1:0] res_mask;
  logic                  do_pop;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [UNIT_W-1:0]     mem_rdata;
  logic                  depth_ovf;

  scua_cfg_regs #(
    .MAX_UNITS(MAX_UNITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  scua_stack_ram #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(free_unit_i),
    .re_i   (do_pop),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_stall_o = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    sel_found = 1'b0;
    sel_pool  = '0;
    for (int p = NUM_POOLS - 1; p >= 0; p--) begin
      if (req_size_i <= cfg.unit_size[p]) begin
        sel_found = 1'b1;
        sel_pool  = POOL_W'(p);
      end
    end
  end

  always_comb begin
    fresh_d    = fresh_q;
    depth_d    = depth_q;
    state_d    = state_q;
    res_status = STAT_OK;
    res_pool   = '0;
    res_unit   = '0;
    do_pop     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ADDR_W'(free_pool_i) * ADDR_W'(MAX_UNITS)
               + ADDR_W'(depth_q[free_pool_i][IDX_W-1:0]);
    mem_raddr  = ADDR_W'(sel_pool) * ADDR_W'(MAX_UNITS)
               + ADDR_W'(IDX_W'(depth_q[sel_pool] - DEPTH_W'(1)));
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (func_e'(func_i))
            FUNC_ALLOC: begin
              if (!sel_found) begin
                res_status = STAT_NO_FIT;
              end else begin
                res_pool = sel_pool;
                priority if (depth_q[sel_pool] != '0) begin
                  depth_d[sel_pool] = depth_q[sel_pool] - DEPTH_W'(1);
                  do_pop            = 1'b1;
                  state_d           = ST_POP;
                end else if (fresh_q[sel_pool] != '0) begin
                  fresh_d[sel_pool] = fresh_q[sel_pool] - COUNT_W'(1);
                  res_unit          = UNIT_W'(fresh_q[sel_pool] - COUNT_W'(1));
                end else begin
                  res_status = STAT_EMPTY;
                end
              end
            end
            FUNC_FREE: begin
              res_pool = free_pool_i;
              priority if ((3'(free_pool_i) >= 3'(NUM_POOLS)) ||
                           (COUNT_W'(free_unit_i) >= cfg.eff_count[free_pool_i])) begin
                res_status = STAT_RANGE;
              end else if (depth_q[free_pool_i] == DEPTH_W'(MAX_UNITS)) begin
                res_status = STAT_STACK_FUL;
              end else begin
                mem_we                = 1'b1;
                depth_d[free_pool_i]  = depth_q[free_pool_i] + DEPTH_W'(1);
              end
            end
            FUNC_REBUILD: begin
              for (int p = 0; p < POOL_SLOTS; p++) begin
                fresh_d[p] = (p < NUM_POOLS) ? cfg.eff_count[p] : '0;
                depth_d[p] = '0;
              end
            end
            FUNC_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    for (int p = 0; p < POOL_SLOTS; p++) begin
      res_mask[p] = (p < NUM_POOLS) && (fresh_d[p] == '0) && (depth_d[p] == '0);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((in_acc && !do_pop) || (state_q == ST_POP)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int p = 0; p < POOL_SLOTS; p++) begin
        fresh_q[p] <= (p < NUM_POOLS) ? COUNT_W'(FRESH_RST) : '0;
        depth_q[p] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      fresh_q     <= fresh_d;
      depth_q     <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= res_status;
      pool_q   <= res_pool;
      unit_q   <= res_unit;
      mask_q   <= res_mask;
    end else if (state_q == ST_POP) begin
      unit_q <= mem_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign pool_o      = pool_q;
  assign unit_o      = unit_q;
  assign full_mask_o = mask_q;

  always_comb begin
    depth_ovf = 1'b0;
    for (int p = 0; p < POOL_SLOTS; p++) begin
      if (depth_q[p] > DEPTH_W'(MAX_UNITS)) begin
        depth_ovf = 1'b1;
      end
    end
  end

  a_acc_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!out_valid_q || !out_stall_i))
    else $error("transaction accepted while result register is held");

  a_pop_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> out_valid_q)
    else $error("stack pop did not produce a result");

  a_pop_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && do_pop) |=> ((state_q == ST_POP) && !out_valid_q))
    else $error("pop transaction did not wait for the stack read");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !depth_ovf)
    else $error("freed stack depth beyond capacity");

endmodule

>>> tb/sv/scua_tb_pkg.sv
// Scoreboard for the size class unit allocator: pool state prediction and result checks.
`timescale 1ns / 1ps

package scua_tb_pkg;

  import scua_pkg::*;

  localparam int NPOOLS = NUM_POOLS_DEF;
  localparam int NUNITS = MAX_UNITS_DEF;

  typedef struct packed {
    status_e                 status;
    logic [POOL_W-1:0]       pool;
    logic [UNIT_W-1:0]       unit;
    logic [POOL_SLOTS-1:0]   full_mask;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [SIZE_W-1:0]  unit_size   [POOL_SLOTS];
    logic [COUNT_W-1:0] count_reg   [POOL_SLOTS];
    logic [COUNT_W-1:0] fresh_left  [POOL_SLOTS];
    logic [COUNT_W-1:0] stack_depth [POOL_SLOTS];
    logic [UNIT_W-1:0]  freed_stack [POOL_SLOTS][NUNITS];
    alloc_result_t      expected_q[$];
    int                 fails;

    function new();
      for (int p = 0; p < POOL_SLOTS; p++) begin
        unit_size[p] = UNIT_SIZE_RST[p];
        count_reg[p] = COUNT_W'(UNIT_COUNT_RST);
      end
      fails = 0;
      reload_pools();
    endfunction

    function int eff_count(int p);
      int c;
      c = count_reg[p];
      if (c > NUNITS) c = NUNITS;
      if (c > UNIT_REACH) c = UNIT_REACH;
      return c;
    endfunction

    function void reload_pools();
      for (int p = 0; p < POOL_SLOTS; p++) begin
        fresh_left[p]  = (p < NPOOLS) ? COUNT_W'(eff_count(p)) : '0;
        stack_depth[p] = '0;
      end
    endfunction

    function logic [POOL_SLOTS-1:0] full_bits();
      logic [POOL_SLOTS-1:0] m;
      m = '0;
      for (int p = 0; p < NPOOLS && p < POOL_SLOTS; p++)
        if (fresh_left[p] == 0 && stack_depth[p] == 0) m[p] = 1'b1;
      return m;
    endfunction

    function void write_reg(int idx, logic [CFG_DATA_W-1:0] data);
      if (idx >= CFG_COUNT_BASE && idx < CFG_COUNT_BASE + POOL_SLOTS)
        count_reg[idx - CFG_COUNT_BASE] = data[COUNT_W-1:0];
      else if (idx >= CFG_SIZE_BASE && idx < CFG_SIZE_BASE + POOL_SLOTS)
        unit_size[idx - CFG_SIZE_BASE] = data[SIZE_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(func_e func, logic [SIZE_W-1:0] req_size,
                               logic [POOL_W-1:0] fpool, logic [UNIT_W-1:0] funit);
      alloc_result_t r;
      int            p;
      bit            found;
      r.status = STAT_OK;
      r.pool   = '0;
      r.unit   = '0;
      found    = 1'b0;
      p        = 0;
      case (func)
        FUNC_ALLOC: begin
          for (int i = 0; i < NPOOLS && i < POOL_SLOTS; i++)
            if (!found && req_size <= unit_size[i]) begin
              found = 1'b1;
              p     = i;
            end
          if (!found) begin
            r.status = STAT_NO_FIT;
          end else begin
            r.pool = POOL_W'(p);
            if (stack_depth[p] > 0) begin
              stack_depth[p] = stack_depth[p] - COUNT_W'(1);
              r.unit = freed_stack[p][stack_depth[p]];
            end else if (fresh_left[p] > 0) begin
              fresh_left[p] = fresh_left[p] - COUNT_W'(1);
              r.unit = fresh_left[p][UNIT_W-1:0];
            end else begin
              r.status = STAT_EMPTY;
            end
          end
        end
        FUNC_FREE: begin
          r.pool = fpool;
          if (int'(fpool) >= NPOOLS || int'(funit) >= eff_count(fpool)) begin
            r.status = STAT_RANGE;
          end else if (stack_depth[fpool] >= NUNITS) begin
            r.status = STAT_STACK_FUL;
          end else begin
            freed_stack[fpool][stack_depth[fpool]] = funit;
            stack_depth[fpool] = stack_depth[fpool] + COUNT_W'(1);
          end
        end
        FUNC_REBUILD: reload_pools();
        default: ;
      endcase
      r.full_mask = full_bits();
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [POOL_W-1:0] pool,
                               logic [UNIT_W-1:0] unit, logic [POOL_SLOTS-1:0] full_mask);
      alloc_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: status %0d pool %0d unit %0d full_mask %0h",
               status, pool, unit, full_mask);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, status);
        fails++;
      end
      if (pool !== e.pool) begin
        $error("pool mismatch: expected %0d, actual %0d", e.pool, pool);
        fails++;
      end
      if (unit !== e.unit) begin
        $error("unit mismatch: expected %0d, actual %0d", e.unit, unit);
        fails++;
      end
      if (full_mask !== e.full_mask) begin
        $error("full_mask mismatch: expected %0h, actual %0h", e.full_mask, full_mask);
        fails++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb_top.sv
// Top-level testbench for the size class unit allocator: stimulus, handshakes and checks.
`timescale 1ns / 1ps

module tb_top;

  import scua_pkg::*;
  import scua_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [FUNC_W-1:0]       func_i      = '0;
  logic [SIZE_W-1:0]       req_size_i  = '0;
  logic [POOL_W-1:0]       free_pool_i = '0;
  logic [UNIT_W-1:0]       free_unit_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [STATUS_W-1:0]     status_o;
  logic [POOL_W-1:0]       pool_o;
  logic [UNIT_W-1:0]       unit_o;
  logic [POOL_SLOTS-1:0]   full_mask_o;

  alloc_scoreboard sb;
  bit              idle_en = 1'b0;
  int              rx_burst = 0;
  int              cycles = 0;

  always #1 clk_i = ~clk_i;

  size_class_unit_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .req_size_i  (req_size_i),
    .free_pool_i (free_pool_i),
    .free_unit_i (free_unit_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .pool_o      (pool_o),
    .unit_o      (unit_o),
    .full_mask_o (full_mask_o)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_request(func_e'(func_i), req_size_i, free_pool_i, free_unit_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(status_o, pool_o, unit_o, full_mask_o);
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk_i) begin
    if (!idle_en) begin
      rx_burst = 0;
      out_stall_i <= 1'b0;
    end else if (rx_burst > 0) begin
      rx_burst--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      rx_burst = $urandom_range(1, 13) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // called and returns at a falling edge
  task automatic send(func_e f, logic [SIZE_W-1:0] req, logic [POOL_W-1:0] fp,
                      logic [UNIT_W-1:0] fu);
    int gap;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i  = 1'b0;
      func_i      = FUNC_W'($urandom);
      req_size_i  = SIZE_W'($urandom);
      free_pool_i = POOL_W'($urandom);
      free_unit_i = UNIT_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    func_i      = f;
    req_size_i  = req;
    free_pool_i = fp;
    free_unit_i = fu;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_IDX_W'(idx);
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [POOL_SLOTS-1:0][SIZE_W-1:0] sizes,
                           logic [POOL_SLOTS-1:0][COUNT_W-1:0] counts, bit reload);
    drain();
    for (int p = 0; p < POOL_SLOTS; p++) begin
      write_reg(CFG_SIZE_BASE + p, sizes[p]);
      write_reg(CFG_COUNT_BASE + p, CFG_DATA_W'(counts[p]));
    end
    if (reload) send(FUNC_REBUILD, '0, '0, '0);
  endtask

  task automatic send_random(int alloc_pct, int rebuild_pct, int hot_pool);
    int                r;
    int                p;
    int                eff;
    logic [SIZE_W-1:0] req;
    logic [POOL_W-1:0] fp;
    logic [UNIT_W-1:0] fu;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, POOL_SLOTS - 1);
    if (r < alloc_pct) begin
      case ($urandom_range(0, 4))
        0:       req = sb.unit_size[p];
        1:       req = sb.unit_size[p] + SIZE_W'(1);
        2:       req = SIZE_W'($urandom_range(0, sb.unit_size[p]));
        3:       req = SIZE_W'($urandom);
        default: req = '0;
      endcase
      send(FUNC_ALLOC, req, POOL_W'($urandom), UNIT_W'($urandom));
    end else if (r < alloc_pct + rebuild_pct) begin
      send(FUNC_REBUILD, SIZE_W'($urandom), POOL_W'($urandom), UNIT_W'($urandom));
    end else if (r < alloc_pct + rebuild_pct + 1) begin
      send(FUNC_NOP, SIZE_W'($urandom), POOL_W'($urandom), UNIT_W'($urandom));
    end else begin
      fp  = (hot_pool >= 0 && $urandom_range(0, 3) != 0) ? POOL_W'(hot_pool)
                                                          : POOL_W'($urandom);
      eff = sb.eff_count(fp);
      fu  = (eff > 0 && $urandom_range(0, 6) != 0) ? UNIT_W'($urandom_range(0, eff - 1))
                                                   : UNIT_W'($urandom);
      send(FUNC_FREE, SIZE_W'($urandom), fp, fu);
    end
  endtask

  task automatic run_phase(int n, int alloc_pct, int rebuild_pct, int hot_pool, bit quiet);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) idle_en = !quiet && ($urandom_range(0, 3) != 0);
      send_random(alloc_pct, rebuild_pct, hot_pool);
    end
  endtask

  initial begin
    logic [POOL_SLOTS-1:0][SIZE_W-1:0]  sizes;
    logic [POOL_SLOTS-1:0][COUNT_W-1:0] counts;
    sb = new();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    idle_en = 1'b1;

    // reset configuration: class boundaries, LIFO reuse, double free, no fit
    send(FUNC_ALLOC, 16'd0, 2'd3, 6'd63);
    send(FUNC_ALLOC, 16'd16, '0, '0);
    send(FUNC_ALLOC, 16'd17, '0, '0);
    send(FUNC_ALLOC, 16'd64, '0, '0);
    send(FUNC_ALLOC, 16'd128, '0, '0);
    send(FUNC_ALLOC, 16'd129, '0, '0);
    send(FUNC_ALLOC, 16'hFFFF, '0, '0);
    send(FUNC_FREE, '0, 2'd0, 6'd5);
    send(FUNC_FREE, '0, 2'd0, 6'd63);
    send(FUNC_ALLOC, 16'd1, '0, '0);
    send(FUNC_ALLOC, 16'd1, '0, '0);
    send(FUNC_FREE, 16'hFFFF, 2'd3, 6'd0);
    send(FUNC_FREE, 16'hFFFF, 2'd3, 6'd0);
    send(FUNC_ALLOC, 16'd100, '0, '0);
    send(FUNC_FREE, '0, 2'd1, 6'd63);
    send(FUNC_FREE, '0, 2'd2, 6'd42);
    send(FUNC_FREE, '0, 2'd1, 6'd21);
    send(FUNC_NOP, 16'hFFFF, 2'd3, 6'd63);
    send(FUNC_ALLOC, 16'hAAAA, '0, '0);
    send(FUNC_REBUILD, 16'h5555, 2'd2, 6'd21);
    send(FUNC_ALLOC, 16'h5555, '0, '0);
    send(FUNC_ALLOC, 16'd32, '0, '0);
    send(FUNC_FREE, '0, 2'd3, 6'd63);

    // size and count extremes, count above the unit reach
    configure({16'd65535, 16'd65534, 16'd1, 16'd0}, {7'd127, 7'd2, 7'd1, 7'd0}, 1'b1);
    run_phase(100, 50, 2, -1, 1'b0);

    // tiny pools: frequent empty and out-of-range frees
    configure({16'd400, 16'd300, 16'd200, 16'd100}, {7'd4, 7'd2, 7'd5, 7'd3}, 1'b1);
    run_phase(120, 50, 3, -1, 1'b0);

    // free flood on one pool until its stack overflows
    configure({16'd128, 16'd64, 16'd32, 16'd16}, {7'd64, 7'd64, 7'd64, 7'd64}, 1'b1);
    run_phase(150, 8, 0, 2, 1'b0);
    run_phase(40, 90, 0, -1, 1'b0);

    // unordered sizes, counts changed without a rebuild
    for (int p = 0; p < POOL_SLOTS; p++) begin
      sizes[p]  = SIZE_W'($urandom);
      counts[p] = COUNT_W'($urandom_range(0, 64));
    end
    configure(sizes, counts, 1'b0);
    run_phase(120, 55, 2, -1, 1'b0);

    configure({16'd65535, 16'd65535, 16'd65535, 16'd65535}, {7'd64, 7'd0, 7'd1, 7'd64},
              1'b1);
    run_phase(80, 60, 2, -1, 1'b0);

    sizes[0] = SIZE_W'($urandom_range(0, 200));
    for (int p = 1; p < POOL_SLOTS; p++)
      sizes[p] = sizes[p-1] + SIZE_W'($urandom_range(1, 500));
    for (int p = 0; p < POOL_SLOTS; p++) counts[p] = COUNT_W'($urandom_range(1, 8));
    configure(sizes, counts, 1'b1);
    run_phase(100, 50, 3, -1, 1'b1);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.fails == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
src/scua_pkg.sv
src/scua_cfg_regs.sv
src/scua_stack_ram.sv
src/size_class_unit_allocator.sv
tb/sv/scua_tb_pkg.sv
tb/sv/tb_top.sv
